// ----- design/bpd_pkg.sv -----
package bpd_pkg;

	// status codes of a result word
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NEED    = 3'd1;
	localparam logic [2:0] ST_DONE    = 3'd2;
	localparam logic [2:0] ST_CORRUPT = 3'd3;
	localparam logic [2:0] ST_BUSY    = 3'd4;

	// input word
	typedef struct packed {
		logic       func;
		logic [7:0] in_byte;
		logic       in_last;
	} bpd_in_t;

	// result word
	typedef struct packed {
		logic        out_valid;
		logic [7:0]  out_byte;
		logic [2:0]  status;
		logic [12:0] out_count;
		logic [12:0] used_count;
	} bpd_out_t;

	// datapath commands
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_FEED,
		CMD_SEEK,
		CMD_TICK,
		CMD_CHK,
		CMD_POP,
		CMD_PUT
	} bpd_cmd_t;

	typedef struct packed {
		bpd_cmd_t cmd;
	} ctl_t;

	// datapath status back to the controller
	typedef struct packed {
		logic is_tick;
		logic again;
		logic seek;
		logic seek_done;
		logic tick_end;
		logic more;
		logic pop;
		logic out_free;
	} sts_t;

endpackage

// ----- design/byte_pair_decompressor.sv -----
// byte pair decompressor: one word in, one result word out, one word in work at a time
// feed word: the word is loaded, fed (fed again at block start) and its result put,
// plus a mask search after the last mask byte and after each mask-table pair
// tick word: loaded, ticked, checked and put (no check when only a status is returned),
// plus a check per level descended, a pop per pending entry; a stalled result holds the input
// reset: asynchronous active low, clears token flags and all counters, limit back to 4096
module byte_pair_decompressor import bpd_pkg::*; #(
	parameter int STACK_DEPTH = 256,
	parameter int MAX_BLOCK   = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  bpd_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output bpd_out_t    out_data
);

	ctl_t ctl;
	sts_t sts;

	// limit register always takes a write
	assign cfg_ready = 1'b1;

	bpd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ctl(ctl),
		.sts(sts)
	);

	bpd_dp #(
		.STACK_DEPTH(STACK_DEPTH),
		.MAX_BLOCK(MAX_BLOCK)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.out_ready(out_ready),
		.out_full(out_valid),
		.out_data(out_data),
		.ctl(ctl),
		.sts(sts)
	);

endmodule

// ----- design/bpd_ram.sv -----
module bpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/bpd_ctrl.sv -----
module bpd_ctrl import bpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output ctl_t ctl,
	input  sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WAIT,
		S_FEED,
		S_SEEK,
		S_TICK,
		S_TWAIT,
		S_CHK,
		S_PWAIT,
		S_POP,
		S_PUT
	} state_t;

	state_t state_q;
	state_t state_d;

	// sequencing and command decode
	always_comb begin
		state_d = state_q;
		ctl.cmd = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.cmd = CMD_LOAD;
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = sts.is_tick ? S_TICK : S_FEED;
			end
			S_FEED: begin
				ctl.cmd = CMD_FEED;
				if (sts.again) begin
					state_d = S_FEED;
				end else if (sts.seek) begin
					state_d = S_SEEK;
				end else begin
					state_d = S_PUT;
				end
			end
			S_SEEK: begin
				ctl.cmd = CMD_SEEK;
				if (sts.seek_done) begin
					state_d = S_PUT;
				end
			end
			S_TICK: begin
				ctl.cmd = CMD_TICK;
				state_d = sts.tick_end ? S_PUT : S_TWAIT;
			end
			S_TWAIT: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				ctl.cmd = CMD_CHK;
				if (sts.more) begin
					state_d = S_TWAIT;
				end else if (sts.pop) begin
					state_d = S_PWAIT;
				end else begin
					state_d = S_PUT;
				end
			end
			S_PWAIT: begin
				state_d = S_POP;
			end
			S_POP: begin
				ctl.cmd = CMD_POP;
				state_d = S_PUT;
			end
			S_PUT: begin
				if (sts.out_free) begin
					ctl.cmd = CMD_PUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/bpd_dp.sv -----
module bpd_dp import bpd_pkg::*; #(
	parameter int STACK_DEPTH = 256,
	parameter int MAX_BLOCK   = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_data,
	input  bpd_in_t     in_data,
	input  logic        out_ready,
	output logic        out_full,
	output bpd_out_t    out_data,
	input  ctl_t        ctl,
	output sts_t        sts
);

	localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int LVW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_ESCAPE,
		PH_TRIPLE,
		PH_MASK,
		PH_PAIRS,
		PH_CODES,
		PH_DONE,
		PH_ERROR
	} phase_t;

	// block state
	logic [12:0]    limit_q;
	bpd_in_t        in_q;
	logic [7:0]     look_q, look_d;
	logic [7:0]     work_q, work_d;
	logic           work_lit_q, work_lit_d;
	logic [7:0]     esc_q, esc_d;
	logic           esc_en_q, esc_en_d;
	logic [8:0]     tokens_q, tokens_d;
	logic [8:0]     cursor_q, cursor_d;
	phase_t         phase_q, phase_d;
	logic [LVW-1:0] level_q, level_d;
	logic [7:0]     cur_q, cur_d;
	logic           pend_q, pend_d;
	logic           esc_pend_q, esc_pend_d;
	logic [12:0]    dec_q, dec_d;
	logic [12:0]    used_q, used_d;
	logic           ended_q, ended_d;
	logic [7:0]     entry_q, entry_d;
	logic           lit_q, lit_d;
	logic [8:0]     ones_q, ones_d;
	logic [255:0]   tok_q, tok_d;
	logic [7:0]     mask_q [32];
	logic           mask_we;
	logic [8:0]     sk_q, sk_d;
	logic [2:0]     res_st_q, res_st_d;
	logic           res_v_q, res_v_d;
	logic [7:0]     res_b_q, res_b_d;
	bpd_out_t       out_q;
	logic           out_full_q;

	// memory ports
	logic           pf_we, ps_we, stk_we;
	logic [7:0]     pw_addr;
	logic [7:0]     pf_rd, ps_rd, stk_rd;
	logic [12:0]    lim;

	// effective output limit
	always_comb begin
		if (limit_q == 13'd0) begin
			lim = 13'd1;
		end else if (32'(limit_q) > 32'(MAX_BLOCK)) begin
			lim = 13'(MAX_BLOCK);
		end else begin
			lim = limit_q;
		end
	end

	assign pw_addr = (phase_q == PH_TRIPLE) ? entry_q : cursor_q[7:0];

	bpd_ram #(.WIDTH(8), .DEPTH(256)) u_first (
		.clk(clk), .we(pf_we), .waddr(pw_addr), .wdata(in_q.in_byte),
		.raddr(look_q), .rdata(pf_rd)
	);

	bpd_ram #(.WIDTH(8), .DEPTH(256)) u_second (
		.clk(clk), .we(ps_we), .waddr(pw_addr), .wdata(in_q.in_byte),
		.raddr(look_q), .rdata(ps_rd)
	);

	bpd_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(level_q[AW-1:0]), .wdata(ps_rd),
		.raddr(level_q[AW-1:0]), .rdata(stk_rd)
	);

	// next-state logic for every command
	always_comb begin
		logic [3:0] pc;
		logic [7:0] sk_byte;
		logic       hit;
		logic [2:0] hit_idx;
		logic [8:0] found;
		logic [8:0] ones_sum;
		logic       expands;
		logic       bad;
		logic       hdr_seek;

		look_d = look_q; work_d = work_q; work_lit_d = work_lit_q;
		esc_d = esc_q; esc_en_d = esc_en_q; tokens_d = tokens_q;
		cursor_d = cursor_q; phase_d = phase_q; level_d = level_q;
		cur_d = cur_q; pend_d = pend_q; esc_pend_d = esc_pend_q;
		dec_d = dec_q; used_d = used_q; ended_d = ended_q;
		entry_d = entry_q; lit_d = lit_q; ones_d = ones_q; tok_d = tok_q;
		sk_d = sk_q; res_st_d = res_st_q; res_v_d = res_v_q; res_b_d = res_b_q;
		pf_we = 1'b0; ps_we = 1'b0; stk_we = 1'b0; mask_we = 1'b0;
		sts = '0;
		sts.is_tick  = in_q.func;
		sts.out_free = !out_full_q || out_ready;
		bad = 1'b0;
		hdr_seek = 1'b0;

		// popcount of the fed byte
		pc = 4'd0;
		for (int i = 0; i < 8; i++) begin
			pc = pc + {3'd0, in_q.in_byte[i]};
		end
		ones_sum = ones_q + {5'd0, pc};

		// one mask byte per cycle, lowest set bit at or above the cursor
		sk_byte = mask_q[sk_q[7:3]];
		hit = 1'b0;
		hit_idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (sk_byte[i] && (3'(i) >= sk_q[2:0])) begin
				hit = 1'b1;
				hit_idx = 3'(i);
			end
		end
		found = sk_q[8] ? 9'd256 : {1'b0, sk_q[7:3], hit_idx};

		expands = !work_lit_q && tok_q[work_q] && (pf_rd != work_q);

		case (ctl.cmd)
			CMD_LOAD: begin
				look_d = in_data.in_byte;
			end
			CMD_FEED: begin
				res_v_d = 1'b0;
				res_b_d = 8'd0;
				res_st_d = ST_OK;
				if (phase_q == PH_DONE || phase_q == PH_ERROR) begin
					if (!ended_q) begin
						ended_d = in_q.in_last;
						res_st_d = (phase_q == PH_DONE) ? ST_DONE : ST_CORRUPT;
					end else begin
						// new block
						sts.again = 1'b1;
						tok_d = '0; esc_d = 8'd0; esc_en_d = 1'b0;
						tokens_d = 9'd0; cursor_d = 9'd0; phase_d = PH_COUNT;
						level_d = '0; cur_d = 8'd0; pend_d = 1'b0;
						esc_pend_d = 1'b0; dec_d = 13'd0; used_d = 13'd0;
						ended_d = 1'b0; entry_d = 8'd0; lit_d = 1'b0;
					end
				end else if (phase_q == PH_CODES && (pend_q || level_q != '0)) begin
					res_st_d = ST_BUSY;
				end else if (phase_q == PH_CODES && dec_q >= lim) begin
					phase_d = PH_DONE;
					ended_d = in_q.in_last;
					res_st_d = ST_DONE;
				end else begin
					if (used_q != 13'h1FFF) begin
						used_d = used_q + 13'd1;
					end
					case (phase_q)
						PH_COUNT: begin
							tokens_d = {1'b0, in_q.in_byte};
							phase_d = (in_q.in_byte != 8'd0) ? PH_ESCAPE : PH_CODES;
						end
						PH_ESCAPE: begin
							esc_d = in_q.in_byte;
							esc_en_d = 1'b1;
							cursor_d = 9'd0;
							ones_d = 9'd0;
							phase_d = (tokens_q < 9'd32) ? PH_TRIPLE : PH_MASK;
						end
						PH_TRIPLE: begin
							if (cursor_q == 9'd0) begin
								entry_d = in_q.in_byte;
								cursor_d = 9'd1;
							end else if (cursor_q == 9'd1) begin
								pf_we = 1'b1;
								cursor_d = 9'd2;
							end else begin
								ps_we = 1'b1;
								tok_d[entry_q] = 1'b1;
								cursor_d = 9'd0;
								tokens_d = tokens_q - 9'd1;
								if (tokens_q == 9'd1) begin
									phase_d = PH_CODES;
								end
							end
						end
						PH_MASK: begin
							mask_we = 1'b1;
							cursor_d = cursor_q + 9'd1;
							ones_d = ones_sum;
							if (cursor_q == 9'd31) begin
								if (ones_sum != tokens_q) begin
									bad = 1'b1;
								end else begin
									hdr_seek = 1'b1;
									sk_d = 9'd0;
									lit_d = 1'b0;
								end
							end
						end
						PH_PAIRS: begin
							if (!lit_q) begin
								pf_we = 1'b1;
								lit_d = 1'b1;
							end else begin
								ps_we = 1'b1;
								tok_d[cursor_q[7:0]] = 1'b1;
								lit_d = 1'b0;
								tokens_d = tokens_q - 9'd1;
								hdr_seek = 1'b1;
								sk_d = cursor_q + 9'd1;
							end
						end
						default: begin
							// code byte
							if (esc_pend_q) begin
								esc_pend_d = 1'b0;
								cur_d = in_q.in_byte;
								lit_d = 1'b1;
								pend_d = 1'b1;
							end else if (esc_en_q && in_q.in_byte == esc_q &&
								!(tok_q[in_q.in_byte] && pf_rd == in_q.in_byte)) begin
								if (in_q.in_last) begin
									res_st_d = ST_CORRUPT;
									phase_d = PH_ERROR;
								end else begin
									esc_pend_d = 1'b1;
								end
							end else begin
								cur_d = in_q.in_byte;
								lit_d = 1'b0;
								pend_d = 1'b1;
							end
						end
					endcase
					ended_d = in_q.in_last;
					// truncated header or bad mask
					if (phase_q != PH_CODES && !hdr_seek && (bad || in_q.in_last)) begin
						res_st_d = ST_CORRUPT;
						phase_d = PH_ERROR;
					end
					sts.seek = hdr_seek;
				end
			end
			CMD_SEEK: begin
				if (sk_q[8] || hit) begin
					sts.seek_done = 1'b1;
					cursor_d = found;
					if (phase_q == PH_MASK) begin
						phase_d = PH_PAIRS;
					end else if (tokens_q == 9'd0 || found[8]) begin
						phase_d = PH_CODES;
					end
					if (in_q.in_last) begin
						res_st_d = ST_CORRUPT;
						phase_d = PH_ERROR;
					end
				end else begin
					sk_d = {sk_q[8:3] + 6'd1, 3'd0};
				end
			end
			CMD_TICK: begin
				res_v_d = 1'b0;
				res_b_d = 8'd0;
				res_st_d = ST_OK;
				if (phase_q == PH_DONE) begin
					res_st_d = ST_DONE;
					sts.tick_end = 1'b1;
				end else if (phase_q == PH_ERROR) begin
					res_st_d = ST_CORRUPT;
					sts.tick_end = 1'b1;
				end else if (phase_q != PH_CODES) begin
					res_st_d = ST_NEED;
					sts.tick_end = 1'b1;
				end else if (!pend_q && level_q == '0) begin
					sts.tick_end = 1'b1;
					if (ended_q && !esc_pend_q) begin
						phase_d = PH_DONE;
						res_st_d = ST_DONE;
					end else begin
						res_st_d = ST_NEED;
					end
				end else begin
					work_d = cur_q;
					look_d = cur_q;
					work_lit_d = lit_q;
				end
			end
			CMD_CHK: begin
				if (expands) begin
					if (level_q >= LVW'(STACK_DEPTH)) begin
						phase_d = PH_ERROR;
						res_st_d = ST_CORRUPT;
					end else begin
						// push the second half, descend into the first
						stk_we = 1'b1;
						level_d = level_q + 1'b1;
						work_d = pf_rd;
						look_d = pf_rd;
						sts.more = 1'b1;
					end
				end else if (dec_q >= lim) begin
					phase_d = PH_ERROR;
					res_st_d = ST_CORRUPT;
				end else begin
					res_v_d = 1'b1;
					res_b_d = work_q;
					dec_d = dec_q + 13'd1;
					lit_d = 1'b0;
					if (level_q != '0) begin
						level_d = level_q - 1'b1;
						sts.pop = 1'b1;
					end else begin
						pend_d = 1'b0;
						if (ended_q) begin
							phase_d = PH_DONE;
							res_st_d = ST_DONE;
						end
					end
				end
			end
			CMD_POP: begin
				cur_d = stk_rd;
				pend_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 13'd4096;
			look_q <= 8'd0; work_q <= 8'd0; work_lit_q <= 1'b0;
			esc_q <= 8'd0; esc_en_q <= 1'b0; tokens_q <= 9'd0;
			cursor_q <= 9'd0; phase_q <= PH_COUNT; level_q <= '0;
			cur_q <= 8'd0; pend_q <= 1'b0; esc_pend_q <= 1'b0;
			dec_q <= 13'd0; used_q <= 13'd0; ended_q <= 1'b0;
			entry_q <= 8'd0; lit_q <= 1'b0; ones_q <= 9'd0; tok_q <= '0;
			sk_q <= 9'd0; res_st_q <= ST_OK; res_v_q <= 1'b0; res_b_q <= 8'd0;
			out_full_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			look_q <= look_d; work_q <= work_d; work_lit_q <= work_lit_d;
			esc_q <= esc_d; esc_en_q <= esc_en_d; tokens_q <= tokens_d;
			cursor_q <= cursor_d; phase_q <= phase_d; level_q <= level_d;
			cur_q <= cur_d; pend_q <= pend_d; esc_pend_q <= esc_pend_d;
			dec_q <= dec_d; used_q <= used_d; ended_q <= ended_d;
			entry_q <= entry_d; lit_q <= lit_d; ones_q <= ones_d; tok_q <= tok_d;
			sk_q <= sk_d; res_st_q <= res_st_d; res_v_q <= res_v_d; res_b_q <= res_b_d;
			if (ctl.cmd == CMD_PUT) begin
				out_full_q <= 1'b1;
			end else if (out_ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.cmd == CMD_LOAD) begin
			in_q <= in_data;
		end
		if (mask_we) begin
			mask_q[cursor_q[4:0]] <= in_q.in_byte;
		end
		if (ctl.cmd == CMD_PUT) begin
			out_q.out_valid  <= res_v_q;
			out_q.out_byte   <= res_b_q;
			out_q.status     <= res_st_q;
			out_q.out_count  <= dec_q;
			out_q.used_count <= used_q;
		end
	end

	assign out_data = out_q;
	assign out_full = out_full_q;

endmodule

// ----- design/bpd_checker.sv -----
module bpd_props import bpd_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input bpd_out_t out_data
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// a decoded byte only comes with an ok or done status
	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_valid |->
		out_data.status == ST_OK || out_data.status == ST_DONE)
		else $error("decoded byte with bad status");

	// busy and needs-input words carry no byte
	a_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_BUSY || out_data.status == ST_NEED) |->
		!out_data.out_valid)
		else $error("byte on busy or needs-input word");

	// one word in work at a time
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

endmodule

bind byte_pair_decompressor bpd_props u_chk (.*);

// ----- tb/bpd_checker.sv -----
`timescale 1ns / 100ps
// watches the three channels of the decompressor, predicts every result word
// and compares it with what the block returns
module bpd_checker import bpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  bpd_in_t     in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  bpd_out_t    out_data,
	output int          fail_count,
	output int          words_waiting,
	output int          words_checked
);

	typedef enum logic [2:0] {
		P_COUNT, P_ESCAPE, P_TRIPLE, P_MASK, P_PAIRS, P_CODES, P_DONE, P_ERROR
	} stage_t;

	localparam int STACK_LEVELS = 256;
	localparam int BLOCK_MAX    = 4096;

	// predicted decoder state
	logic [12:0] limit_reg;
	logic [7:0]  pair_a [256];
	logic [7:0]  pair_b [256];
	bit          token_flag [256];
	logic [7:0]  mask_bytes [32];
	logic [7:0]  esc_byte;
	bit          esc_on;
	int          tok_left;
	int          cursor;
	stage_t      stage;
	logic [7:0]  pend [STACK_LEVELS];
	int          depth;
	logic [7:0]  cur_sym;
	bit          sym_waiting;
	bit          esc_waiting;
	int          n_decoded;
	int          n_used;
	bit          block_closed;
	logic [7:0]  entry;
	bit          sym_raw;

	bpd_out_t expected_q[$];

	function automatic int eff_limit();
		int l;
		l = limit_reg;
		if (l < 1) l = 1;
		if (l > BLOCK_MAX) l = BLOCK_MAX;
		return l;
	endfunction

	function automatic int next_marked(int from);
		for (int b = from; b < 256; b++)
			if (mask_bytes[b >> 3][b & 7]) return b;
		return 256;
	endfunction

	task automatic open_block();
		for (int i = 0; i < 256; i++) token_flag[i] = 0;
		esc_byte = 0; esc_on = 0; tok_left = 0; cursor = 0; stage = P_COUNT;
		depth = 0; cur_sym = 0; sym_waiting = 0; esc_waiting = 0;
		n_decoded = 0; n_used = 0; block_closed = 0; entry = 0; sym_raw = 0;
	endtask

	// one compressed byte
	task automatic take_byte(input logic [7:0] v, input bit last, output logic [2:0] st);
		int ones;
		st = ST_OK;
		if (stage == P_DONE || stage == P_ERROR) begin
			if (!block_closed) begin
				block_closed = last;
				st = (stage == P_DONE) ? ST_DONE : ST_CORRUPT;
				return;
			end
			open_block();
		end
		if (stage == P_CODES && (sym_waiting || depth != 0)) begin
			st = ST_BUSY;
			return;
		end
		if (stage == P_CODES && n_decoded >= eff_limit()) begin
			stage = P_DONE;
			block_closed = last;
			st = ST_DONE;
			return;
		end
		if (n_used < 8191) n_used++;
		case (stage)
			P_COUNT: begin
				tok_left = v;
				stage = (v != 0) ? P_ESCAPE : P_CODES;
			end
			P_ESCAPE: begin
				esc_byte = v; esc_on = 1; cursor = 0;
				stage = (tok_left < 32) ? P_TRIPLE : P_MASK;
			end
			P_TRIPLE: begin
				if (cursor == 0) begin
					entry = v; cursor = 1;
				end else if (cursor == 1) begin
					pair_a[entry] = v; cursor = 2;
				end else begin
					pair_b[entry] = v; token_flag[entry] = 1; cursor = 0;
					tok_left--;
					if (tok_left == 0) stage = P_CODES;
				end
			end
			P_MASK: begin
				mask_bytes[cursor & 31] = v;
				cursor++;
				if (cursor >= 32) begin
					ones = 0;
					for (int i = 0; i < 32; i++) ones += $countones(mask_bytes[i]);
					if (ones != tok_left) begin
						st = ST_CORRUPT;
					end else begin
						cursor = next_marked(0);
						sym_raw = 0;
						stage = P_PAIRS;
					end
				end
			end
			P_PAIRS: begin
				if (!sym_raw) begin
					pair_a[cursor & 255] = v; sym_raw = 1;
				end else begin
					pair_b[cursor & 255] = v; token_flag[cursor & 255] = 1; sym_raw = 0;
					tok_left--;
					cursor = next_marked(cursor + 1);
					if (tok_left == 0 || cursor > 255) stage = P_CODES;
				end
			end
			default: begin
				// code byte: escaped literal, escape marker or symbol
				if (esc_waiting) begin
					esc_waiting = 0;
					cur_sym = v; sym_raw = 1; sym_waiting = 1;
				end else if (esc_on && v == esc_byte &&
						!(token_flag[v] && pair_a[v] == v)) begin
					if (last) st = ST_CORRUPT;
					else esc_waiting = 1;
				end else begin
					cur_sym = v; sym_raw = 0; sym_waiting = 1;
				end
				block_closed = last;
				if (st == ST_CORRUPT) stage = P_ERROR;
				return;
			end
		endcase
		block_closed = last;
		// header cut short by the last flag
		if (st == ST_OK && last) st = ST_CORRUPT;
		if (st == ST_CORRUPT) stage = P_ERROR;
	endtask

	// one tick: emit the next decoded byte if there is one
	task automatic take_tick(output bit vld, output logic [7:0] b, output logic [2:0] st);
		logic [7:0] s;
		vld = 0; b = 0; st = ST_OK;
		if (stage == P_DONE) begin st = ST_DONE; return; end
		if (stage == P_ERROR) begin st = ST_CORRUPT; return; end
		if (stage != P_CODES) begin st = ST_NEED; return; end
		if (!sym_waiting && depth == 0) begin
			if (block_closed && !esc_waiting) begin
				stage = P_DONE; st = ST_DONE;
			end else begin
				st = ST_NEED;
			end
			return;
		end
		s = cur_sym;
		// descend the pair chain, pushing right halves
		if (!sym_raw) begin
			while (token_flag[s] && pair_a[s] != s) begin
				if (depth >= STACK_LEVELS) begin
					stage = P_ERROR; st = ST_CORRUPT;
					return;
				end
				pend[depth] = pair_b[s];
				depth++;
				s = pair_a[s];
			end
		end
		if (n_decoded >= eff_limit()) begin
			stage = P_ERROR; st = ST_CORRUPT;
			return;
		end
		vld = 1; b = s;
		n_decoded++;
		sym_raw = 0;
		if (depth != 0) begin
			depth--;
			cur_sym = pend[depth];
			sym_waiting = 1;
		end else begin
			sym_waiting = 0;
			if (block_closed) begin stage = P_DONE; st = ST_DONE; end
		end
	endtask

	task automatic predict_word(input bpd_in_t w, output bpd_out_t r);
		bit vld;
		logic [7:0] b;
		logic [2:0] st;
		vld = 0; b = 0;
		if (w.func) take_tick(vld, b, st);
		else take_byte(w.in_byte, w.in_last, st);
		r.out_valid  = vld;
		r.out_byte   = b;
		r.status     = st;
		r.out_count  = n_decoded[12:0];
		r.used_count = n_used[12:0];
	endtask

	// compare older results first, then predict the newly accepted word
	always @(posedge clk or negedge arst_n) begin
		bpd_out_t exp_w;
		bpd_out_t got_w;
		if (!arst_n) begin
			limit_reg = 13'd4096;
			open_block();
			expected_q.delete();
			fail_count = 0;
			words_checked = 0;
			words_waiting = 0;
		end else begin
			if (out_valid && out_ready) begin
				got_w = out_data;
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t unexpected result word %h", $time, got_w);
				end else begin
					exp_w = expected_q.pop_front();
					words_checked++;
					if (got_w !== exp_w) begin
						fail_count++;
						$display("%0t mismatch: expected v=%0d byte=%h st=%0d out=%0d used=%0d",
							$time, exp_w.out_valid, exp_w.out_byte, exp_w.status,
							exp_w.out_count, exp_w.used_count);
						$display("%0t mismatch: actual   v=%0d byte=%h st=%0d out=%0d used=%0d",
							$time, got_w.out_valid, got_w.out_byte, got_w.status,
							got_w.out_count, got_w.used_count);
					end
				end
			end
			if (cfg_valid && cfg_ready) limit_reg = cfg_data;
			if (in_valid && in_ready) begin
				predict_word(in_data, exp_w);
				expected_q.push_back(exp_w);
			end
			words_waiting = expected_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
	import bpd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [12:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	bpd_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	bpd_out_t    out_data;

	int fail_count;
	int words_waiting;
	int words_checked;

	byte_pair_decompressor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	bpd_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.fail_count    (fail_count),
		.words_waiting (words_waiting),
		.words_checked (words_checked)
	);

	bpd_in_t    word_q[$];
	logic [7:0] hdr_q[$];
	bit         tok_set [256];
	logic [7:0] tok_a [256];
	logic [7:0] tok_b [256];
	int         tok_depth [256];
	int         words_sent;
	int         blocks_sent;
	bit         no_gaps;
	bit         rx_calm;
	bit         hold_req;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				hold_req = 0;
			end else if (stall_left > 0) begin
				out_ready <= 0;
				stall_left--;
			end else begin
				out_ready <= 1;
				if (!rx_calm) begin
					if ($urandom_range(0, 99) < 12) stall_left = $urandom_range(1, 3);
					else if ($urandom_range(0, 99) < 3) stall_left = $urandom_range(10, 40);
				end
			end
		end
	end

	function automatic int gap_len();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_word(input bpd_in_t w);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_data <= w;
		in_valid <= 1;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		words_sent++;
	endtask

	task automatic play_words();
		while (word_q.size() != 0) send_word(word_q.pop_front());
		in_valid <= 0;
	endtask

	task automatic push_byte(input logic [7:0] v, input bit last);
		bpd_in_t w;
		w.func = 0; w.in_byte = v; w.in_last = last;
		word_q.push_back(w);
	endtask

	task automatic push_ticks(input int n);
		bpd_in_t w;
		repeat (n) begin
			w.func = 1; w.in_byte = 8'($urandom); w.in_last = 1'($urandom);
			word_q.push_back(w);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (words_waiting != 0);
		@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_limit(input logic [12:0] v);
		cfg_data <= v;
		cfg_valid <= 1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] v;
		do v = 8'($urandom); while (tok_set[v]);
		return v;
	endfunction

	// one block: header with a token table, code bytes and draining ticks
	task automatic make_block();
		int n, m, mode, k, pick, cnt;
		bit cyclic, bad_mask, cut;
		logic [7:0] esc, v, c0, c1;
		logic [7:0] toks[$];
		logic [7:0] mask[32];
		hdr_q.delete();
		toks.delete();
		for (int i = 0; i < 256; i++) begin tok_set[i] = 0; tok_depth[i] = 0; end
		mode = $urandom_range(0, 9);
		if (mode == 0) n = 0;
		else if (mode < 7) n = $urandom_range(1, 8);
		else n = $urandom_range(32, 44);
		cnt = 0;
		while (cnt < n) begin
			v = 8'($urandom);
			if (!tok_set[v]) begin tok_set[v] = 1; cnt++; end
		end
		for (int b = 0; b < 256; b++) if (tok_set[b]) toks.push_back(8'(b));
		// pair operands: literals or shallower earlier tokens, now and then a self pair
		for (int i = 0; i < toks.size(); i++) begin
			for (int h = 0; h < 2; h++) begin
				pick = $urandom_range(0, 9);
				if (h == 0 && pick == 0) v = toks[i];
				else if (i > 0 && pick < 5) begin
					v = toks[$urandom_range(0, i - 1)];
					if (tok_depth[v] >= 2) v = plain_byte();
				end else v = plain_byte();
				if (h == 0) tok_a[toks[i]] = v; else tok_b[toks[i]] = v;
				if (v != toks[i] && tok_set[v] && tok_depth[v] + 1 > tok_depth[toks[i]])
					tok_depth[toks[i]] = tok_depth[v] + 1;
			end
		end
		cyclic = (n >= 2) && ($urandom_range(0, 11) == 0);
		if (cyclic) begin
			tok_a[toks[0]] = toks[1];
			tok_a[toks[1]] = toks[0];
		end
		esc = ($urandom_range(0, 4) == 0 && n > 0) ? toks[$urandom_range(0, n - 1)]
			: 8'($urandom);
		hdr_q.push_back(8'(n));
		if (n > 0) hdr_q.push_back(esc);
		if (n > 0 && n < 32) begin
			foreach (toks[i]) begin
				hdr_q.push_back(toks[i]);
				hdr_q.push_back(tok_a[toks[i]]);
				hdr_q.push_back(tok_b[toks[i]]);
			end
		end else if (n >= 32) begin
			for (int i = 0; i < 32; i++) mask[i] = 0;
			foreach (toks[i]) mask[toks[i] >> 3][toks[i] & 7] = 1;
			bad_mask = ($urandom_range(0, 9) == 0);
			if (bad_mask) begin
				v = plain_byte();
				mask[v >> 3][v & 7] = 1;
			end
			for (int i = 0; i < 32; i++) hdr_q.push_back(mask[i]);
			foreach (toks[i]) begin
				hdr_q.push_back(tok_a[toks[i]]);
				hdr_q.push_back(tok_b[toks[i]]);
			end
		end
		// a header cut short
		cut = ($urandom_range(0, 11) == 0);
		if (cut) begin
			k = $urandom_range(0, hdr_q.size() - 1);
			for (int i = 0; i < k; i++) push_byte(hdr_q[i], 0);
			push_byte(hdr_q[k], 1);
			push_ticks($urandom_range(1, 3));
			return;
		end
		foreach (hdr_q[i]) push_byte(hdr_q[i], 0);
		m = $urandom_range(1, 10);
		for (int i = 0; i < m; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40 || n == 0) v = plain_byte();
			else if (pick < 75) v = toks[$urandom_range(0, n - 1)];
			else if (pick < 90) v = esc;
			else v = 8'($urandom);
			if (i == m - 1) push_ticks(10);
			push_byte(v, i == m - 1);
			push_ticks((i == m - 1) ? 20 : $urandom_range(0, 6));
		end
		blocks_sent++;
	endtask

	initial begin
		logic [12:0] limits[8];
		int phase_no;
		int guard;
		limits = '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd5, 13'd3, 13'd40, 13'd0};
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = 0;
		in_valid = 0;
		in_data = '0;
		words_sent = 0;
		blocks_sent = 0;
		no_gaps = 0;
		rx_calm = 0;
		hold_req = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: token, escaped marker, literal edges, tick with nothing to emit
		write_limit(13'd4096);
		push_ticks(1);
		push_byte(8'h01, 0);
		push_byte(8'hFF, 0);
		push_byte(8'h80, 0); push_byte(8'h41, 0); push_byte(8'h42, 0);
		push_byte(8'h80, 0); push_ticks(3);
		push_byte(8'hFF, 0); push_byte(8'hFF, 0); push_ticks(2);
		push_byte(8'h00, 0); push_ticks(2);
		push_byte(8'h7F, 1); push_ticks(3);
		play_words();
		wait_idle();

		phase_no = 0;
		while (words_sent < 550) begin
			limits[7] = 13'($urandom_range(1, 4096));
			write_limit(limits[phase_no % 8]);
			no_gaps = (phase_no % 4 == 3) || (phase_no == 0);
			rx_calm = (phase_no % 5 == 4);
			if (phase_no == 0) hold_req = 1;
			repeat ($urandom_range(2, 4)) begin
				if (words_sent + word_q.size() < 550) make_block();
			end
			play_words();
			wait_idle();
			phase_no++;
		end

		guard = 0;
		while (words_waiting != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		$display("sent %0d words in %0d random blocks plus directed words, %0d results checked",
			words_sent, blocks_sent, words_checked);
		$display("output limits swept over %0d settings including 0, 1 and 8191", phase_no);
		if (fail_count == 0 && words_waiting == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/bpd_pkg.sv
design/bpd_ram.sv
design/bpd_ctrl.sv
design/bpd_dp.sv
design/byte_pair_decompressor.sv
design/bpd_checker.sv
tb/bpd_checker.sv
tb/tb_top.sv
